// ----- hw/rtl/lvjd_pkg.sv -----
// Shared types and constants for the liveness jitter decision block.
// Used by the front end, divider, back end and top level; depends on nothing else.

package lvjd_pkg;

    // Window sizes.
    localparam int JITTER_WINDOW = 15;
    localparam int WARMUP_FRAMES = 8;
    localparam int LOGIT_WINDOW  = 3;

    // Field widths.
    localparam int POINT_W  = 16;
    localparam int LOGIT_W  = 16;
    localparam int WIDTH_W  = 12;
    localparam int DELTA_W  = POINT_W + 1;
    localparam int COORDS   = 8;
    localparam int COORD_W  = 24;
    localparam int VAR_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Derived sizes of the landmark window.
    localparam int SLOT_W    = $clog2(JITTER_WINDOW);
    localparam int CNT_W     = $clog2(JITTER_WINDOW + 1);
    localparam int MEM_DEPTH = JITTER_WINDOW * COORDS;
    localparam int ADDR_W    = SLOT_W + 3;
    localparam int SUM_W     = COORD_W + $clog2(JITTER_WINDOW);
    localparam int SQ_W      = 2 * COORD_W;
    localparam int SQS_W     = SQ_W + $clog2(MEM_DEPTH);
    localparam int SSQ_W     = 2 * SUM_W + 2;

    // Derived sizes of the logit window.
    localparam int LCNT_W = $clog2(LOGIT_WINDOW + 1);
    localparam int LIDX_W = (LOGIT_WINDOW > 1) ? $clog2(LOGIT_WINDOW) : 1;

    // Divider geometry.
    localparam int DIVIDEND_W = 64;
    localparam int DEN_W      = 36;
    localparam int QB_COORD   = COORD_W;
    localparam int QB_VAR     = VAR_W;
    localparam int DD_W       = DEN_W + QB_VAR - 1;
    localparam int QCNT_W     = $clog2(QB_VAR + 1);

    // Input queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Arithmetic constants.
    localparam logic [VAR_W-1:0]          WARMUP_VARIANCE = 32'd42949673;
    localparam logic signed [14:0]        WIDTH_SCALE     = 15'sd10240;
    localparam logic signed [COORD_W-1:0] COORD_MAX       = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN       = 24'sh800000;

    // Register reset values.
    localparam logic signed [LOGIT_W-1:0] LIVE_THRESHOLD_RESET = 16'sd384;
    localparam logic [VAR_W-1:0]          VARIANCE_LOW_RESET   = 32'd64425;
    localparam logic [VAR_W-1:0]          VARIANCE_HIGH_RESET  = 32'd3435974;
    localparam logic signed [LOGIT_W-1:0] OVERRIDE_FLOOR_RESET = -16'sd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIVE_THRESHOLD = 8'd0,
        CFG_VARIANCE_LOW   = 8'd1,
        CFG_VARIANCE_HIGH  = 8'd2,
        CFG_OVERRIDE_FLOOR = 8'd3
    } lvjd_cfg_idx_t;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] live_threshold;
        logic [VAR_W-1:0]          variance_low;
        logic [VAR_W-1:0]          variance_high;
        logic signed [LOGIT_W-1:0] override_floor;
    } lvjd_cfg_t;

    // One classified frame as it waits in the queue.
    typedef struct packed {
        logic                          absent;
        logic                          skip;
        logic signed [LOGIT_W-1:0]     logit;
        logic [WIDTH_W-1:0]            width;
        logic [COORDS-1:0][POINT_W-1:0] pts;
        logic signed [DELTA_W-1:0]     ex;
        logic signed [DELTA_W-1:0]     ey;
    } lvjd_item_t;

endpackage

// ----- hw/rtl/lvjd_front.sv -----
// Front end: accepts frames, classifies them and holds them in a short queue.
// Depends on lvjd_pkg for the item type and queue sizes.

module lvjd_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    face_present,
    input  logic signed [15:0]      logit_diff,
    input  logic [11:0]             face_width,
    input  logic signed [15:0]      right_eye_dx,
    input  logic signed [15:0]      right_eye_dy,
    input  logic signed [15:0]      left_eye_dx,
    input  logic signed [15:0]      left_eye_dy,
    input  logic signed [15:0]      right_mouth_dx,
    input  logic signed [15:0]      right_mouth_dy,
    input  logic signed [15:0]      left_mouth_dx,
    input  logic signed [15:0]      left_mouth_dy,
    output lvjd_pkg::lvjd_item_t    head,
    output logic                    head_valid,
    input  logic                    pop
);
    import lvjd_pkg::*;

    lvjd_item_t          item_c;
    lvjd_item_t          queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QFILL_W-1:0]  fill_reg;
    logic                push;
    logic                take;

    // Classify the frame and form the eye vector up front.
    always_comb
    begin
        item_c.absent = ~face_present;
        item_c.skip   = (face_width == '0);
        item_c.logit  = logit_diff;
        item_c.width  = face_width;
        item_c.pts[0] = right_eye_dx;
        item_c.pts[1] = right_eye_dy;
        item_c.pts[2] = left_eye_dx;
        item_c.pts[3] = left_eye_dy;
        item_c.pts[4] = right_mouth_dx;
        item_c.pts[5] = right_mouth_dy;
        item_c.pts[6] = left_mouth_dx;
        item_c.pts[7] = left_mouth_dy;
        item_c.ex = {left_eye_dx[15], left_eye_dx} - {right_eye_dx[15], right_eye_dx};
        item_c.ey = {left_eye_dy[15], left_eye_dy} - {right_eye_dy[15], right_eye_dy};
    end

    assign in_ready   = (fill_reg != QFILL_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = queue_mem[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign take       = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (take)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            if (push && !take)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (take && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= item_c;
        end
    end

endmodule

// ----- hw/rtl/lvjd_div.sv -----
// Shared restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on lvjd_pkg for the divider geometry.

module lvjd_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            var_mode,
    input  logic [lvjd_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [lvjd_pkg::DEN_W-1:0]      divisor,
    output logic                            done,
    output logic                            sat,
    output logic [lvjd_pkg::QB_VAR-1:0]     quotient
);
    import lvjd_pkg::*;

    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DD_W-1:0]       dd_reg;
    logic [QB_VAR-1:0]     q_reg;
    logic                  sat_reg;
    logic [QCNT_W-1:0]     cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  sat_c;
    logic                  ge_c;
    logic [DD_W-1:0]       dd_init_c;

    // The quotient overflows its field exactly when the dividend shifted
    // down by the field width still reaches the divisor.
    assign sat_c = var_mode ? (DIVIDEND_W'(dividend >> QB_VAR) >= DIVIDEND_W'(divisor))
                            : (DIVIDEND_W'(dividend >> QB_COORD) >= DIVIDEND_W'(divisor));
    assign dd_init_c = var_mode ? (DD_W'(divisor) << (QB_VAR - 1))
                                : (DD_W'(divisor) << (QB_COORD - 1));
    assign ge_c = ({(DD_W - DIVIDEND_W)'(0), rem_reg} >= dd_reg);

    assign done     = done_reg;
    assign sat      = sat_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= ~sat_c;
            done_reg <= sat_c;
            cnt_reg  <= var_mode ? QCNT_W'(QB_VAR) : QCNT_W'(QB_COORD);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == QCNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dd_reg  <= dd_init_c;
            q_reg   <= '0;
            sat_reg <= sat_c;
        end
        else if (busy_reg)
        begin
            if (ge_c)
            begin
                rem_reg <= rem_reg - dd_reg[DIVIDEND_W-1:0];
            end
            q_reg  <= {q_reg[QB_VAR-2:0], ge_c};
            dd_reg <= dd_reg >> 1;
        end
    end

endmodule

// ----- hw/rtl/lvjd_back.sv -----
// Back end: logit window, landmark alignment, jitter window and decision.
// Depends on lvjd_pkg and lvjd_div; owns the landmark window memory.

module lvjd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lvjd_pkg::lvjd_item_t   head,
    input  logic                   head_valid,
    output logic                   pop,
    input  lvjd_pkg::lvjd_cfg_t    cfg,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   is_live,
    output logic                   micro_movement,
    output logic [31:0]            jitter_variance,
    output logic                   logit_stable
);
    import lvjd_pkg::*;

    localparam int NUM_W  = 50;
    localparam int PROD_W = 33;

    typedef enum logic [3:0] {
        B_IDLE, B_LOGIT, B_SETUP, B_PROD, B_NUM, B_DIV, B_RD, B_SQ, B_ACC,
        B_VMUL, B_VACC, B_VNUM, B_VDIV, B_DEC, B_DONE
    } back_state_t;

    back_state_t                state_reg;
    logic [2:0]                 k_reg;
    logic [LCNT_W-1:0]          logit_count_reg;
    logic [LIDX_W-1:0]          logit_oldest_reg;
    logic [CNT_W-1:0]           aligned_count_reg;
    logic [SLOT_W-1:0]          aligned_oldest_reg;
    logic signed [SUM_W-1:0]    sums_reg [COORDS];
    logic [SQS_W-1:0]           square_sum_reg;
    logic                       out_valid_reg;
    logic                       is_live_reg;
    logic                       micro_movement_reg;
    logic [VAR_W-1:0]           jitter_variance_reg;
    logic                       logit_stable_reg;

    lvjd_item_t                 item_reg;
    logic signed [LOGIT_W-1:0]  logit_store_reg [LOGIT_WINDOW];
    logic [DEN_W-1:0]           d2_reg;
    logic                       full_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic signed [PROD_W-1:0]   prod_a_reg;
    logic signed [PROD_W-1:0]   prod_b_reg;
    logic                       neg_reg;
    logic signed [COORD_W-1:0]  co_reg [COORDS];
    logic signed [COORD_W-1:0]  rd_data_reg;
    logic [SQ_W-1:0]            sqo_reg;
    logic [SQ_W-1:0]            sqn_reg;
    logic [2*SUM_W-1:0]         vsq_reg;
    logic [SSQ_W-1:0]           ssq_reg;
    logic [VAR_W-1:0]           var_reg;
    logic                       stable_reg;
    logic                       moving_reg;
    logic                       live_reg;
    logic signed [COORD_W-1:0]  aligned_mem [MEM_DEPTH];

    logic                       logit_full_c;
    logic [LIDX_W-1:0]          logit_widx_c;
    logic [LOGIT_WINDOW-1:0]    pass_c;
    logic                       aligned_full_c;
    logic [SLOT_W-1:0]          slot_c;
    logic signed [35:0]         d2_c;
    logic signed [POINT_W-1:0]  px_c;
    logic signed [POINT_W-1:0]  py_c;
    logic signed [33:0]         dot_c;
    logic signed [NUM_W-1:0]    num_c;
    logic [NUM_W-1:0]           mag_c;
    logic [DEN_W-1:0]           den_c;
    logic [2*CNT_W-1:0]         nn_c;
    logic [DIVIDEND_W-1:0]      nsq_c;
    logic                       warm_c;
    logic                       div_start;
    logic                       div_var;
    logic [DIVIDEND_W-1:0]      div_dividend;
    logic [DEN_W-1:0]           div_divisor;
    logic                       div_done;
    logic                       div_sat;
    logic [QB_VAR-1:0]          div_q;
    logic                       co_ovf_c;
    logic signed [COORD_W-1:0]  q_s_c;
    logic signed [COORD_W-1:0]  co_c;
    logic signed [SQ_W-1:0]     sqo_c;
    logic signed [SQ_W-1:0]     sqn_c;
    logic [SUM_W-1:0]           vmag_c;
    logic [ADDR_W-1:0]          addr_c;
    logic                       moving_c;
    logic                       load_out;
    int                         lsum;
    int                         asum;

    // Window bookkeeping.
    always_comb
    begin
        lsum = int'(logit_oldest_reg) + int'(logit_count_reg);
        if (lsum >= LOGIT_WINDOW)
        begin
            lsum = lsum - LOGIT_WINDOW;
        end
        asum = int'(aligned_oldest_reg) + int'(aligned_count_reg);
        if (asum >= JITTER_WINDOW)
        begin
            asum = asum - JITTER_WINDOW;
        end
        logit_full_c   = (logit_count_reg == LCNT_W'(LOGIT_WINDOW));
        logit_widx_c   = logit_full_c ? logit_oldest_reg : LIDX_W'(lsum);
        aligned_full_c = (aligned_count_reg == CNT_W'(JITTER_WINDOW));
        slot_c         = aligned_full_c ? aligned_oldest_reg : SLOT_W'(asum);
    end

    for (genvar i = 0; i < LOGIT_WINDOW; i++)
    begin : g_pass
        assign pass_c[i] = (logit_store_reg[i] >= cfg.live_threshold);
    end

    // Alignment arithmetic for coordinate k.
    always_comb
    begin
        d2_c  = item_reg.ex * item_reg.ex + item_reg.ey * item_reg.ey;
        px_c  = $signed(item_reg.pts[{k_reg[2:1], 1'b0}]);
        py_c  = $signed(item_reg.pts[{k_reg[2:1], 1'b1}]);
        dot_c = k_reg[0] ? (prod_a_reg - prod_b_reg) : (prod_a_reg + prod_b_reg);
        if (d2_reg != '0)
        begin
            num_c = $signed({dot_c, 16'b0});
            den_c = d2_reg;
        end
        else
        begin
            num_c = NUM_W'(dot_c);
            den_c = DEN_W'(item_reg.width);
        end
        mag_c = num_c[NUM_W-1] ? unsigned'(-num_c) : unsigned'(num_c);
    end

    // Variance arithmetic.
    assign nn_c   = aligned_count_reg * aligned_count_reg;
    assign nsq_c  = DIVIDEND_W'(aligned_count_reg) * DIVIDEND_W'(square_sum_reg);
    assign warm_c = (int'(aligned_count_reg) >= WARMUP_FRAMES);

    always_comb
    begin
        div_var = (state_reg == B_VNUM);
        if (div_var)
        begin
            div_dividend = nsq_c - DIVIDEND_W'(ssq_reg);
            div_divisor  = DEN_W'({nn_c, 3'b000});
        end
        else
        begin
            div_dividend = DIVIDEND_W'(mag_c) + DIVIDEND_W'(den_c >> 1);
            div_divisor  = den_c;
        end
        div_start = (state_reg == B_NUM) ||
                    ((state_reg == B_VNUM) && (aligned_count_reg != '0) && warm_c);
    end

    lvjd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .var_mode (div_var),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .sat      (div_sat),
        .quotient (div_q)
    );

    // Round-to-nearest quotient back to a saturated signed coordinate.
    always_comb
    begin
        co_ovf_c = div_sat || div_q[COORD_W-1];
        q_s_c    = $signed(div_q[COORD_W-1:0]);
        if (neg_reg)
        begin
            co_c = co_ovf_c ? COORD_MIN : -q_s_c;
        end
        else
        begin
            co_c = co_ovf_c ? COORD_MAX : q_s_c;
        end
    end

    assign sqo_c    = rd_data_reg * rd_data_reg;
    assign sqn_c    = co_reg[k_reg] * co_reg[k_reg];
    assign vmag_c   = sums_reg[k_reg][SUM_W-1] ? unsigned'(-sums_reg[k_reg])
                                               : unsigned'(sums_reg[k_reg]);
    assign addr_c   = {slot_reg, k_reg};
    assign moving_c = (var_reg >= cfg.variance_low) && (var_reg <= cfg.variance_high);
    assign load_out = (state_reg == B_DONE) && (!out_valid_reg || out_ready);
    assign pop      = (state_reg == B_IDLE) && head_valid;

    assign out_valid       = out_valid_reg;
    assign is_live         = is_live_reg;
    assign micro_movement  = micro_movement_reg;
    assign jitter_variance = jitter_variance_reg;
    assign logit_stable    = logit_stable_reg;

    // Sequencer, window counters, running sums and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= B_IDLE;
            k_reg               <= '0;
            logit_count_reg     <= '0;
            logit_oldest_reg    <= '0;
            aligned_count_reg   <= '0;
            aligned_oldest_reg  <= '0;
            sums_reg            <= '{default: '0};
            square_sum_reg      <= '0;
            out_valid_reg       <= 1'b0;
            is_live_reg         <= 1'b0;
            micro_movement_reg  <= 1'b0;
            jitter_variance_reg <= '0;
            logit_stable_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (head_valid)
                    begin
                        state_reg <= B_LOGIT;
                    end
                end
                B_LOGIT:
                begin
                    if (item_reg.absent)
                    begin
                        logit_count_reg    <= '0;
                        logit_oldest_reg   <= '0;
                        aligned_count_reg  <= '0;
                        aligned_oldest_reg <= '0;
                        sums_reg           <= '{default: '0};
                        square_sum_reg     <= '0;
                        state_reg          <= B_DONE;
                    end
                    else
                    begin
                        if (logit_full_c)
                        begin
                            logit_oldest_reg <= (logit_oldest_reg == LIDX_W'(LOGIT_WINDOW - 1))
                                                ? '0 : logit_oldest_reg + 1'b1;
                        end
                        else
                        begin
                            logit_count_reg <= logit_count_reg + 1'b1;
                        end
                        state_reg <= B_SETUP;
                    end
                end
                B_SETUP:
                begin
                    k_reg     <= '0;
                    state_reg <= item_reg.skip ? B_VMUL : B_PROD;
                end
                B_PROD:
                begin
                    state_reg <= B_NUM;
                end
                B_NUM:
                begin
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    if (div_done)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= (k_reg == 3'd7) ? B_RD : B_PROD;
                    end
                end
                B_RD:
                begin
                    state_reg <= B_SQ;
                end
                B_SQ:
                begin
                    state_reg <= B_ACC;
                end
                B_ACC:
                begin
                    sums_reg[k_reg] <= sums_reg[k_reg] + SUM_W'(co_reg[k_reg])
                                       - (full_reg ? SUM_W'(rd_data_reg) : SUM_W'(0));
                    square_sum_reg  <= square_sum_reg + SQS_W'(sqn_reg)
                                       - (full_reg ? SQS_W'(sqo_reg) : SQS_W'(0));
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'd7)
                    begin
                        if (full_reg)
                        begin
                            aligned_oldest_reg <=
                                (aligned_oldest_reg == SLOT_W'(JITTER_WINDOW - 1))
                                ? '0 : aligned_oldest_reg + 1'b1;
                        end
                        else
                        begin
                            aligned_count_reg <= aligned_count_reg + 1'b1;
                        end
                        state_reg <= B_VMUL;
                    end
                    else
                    begin
                        state_reg <= B_RD;
                    end
                end
                B_VMUL:
                begin
                    state_reg <= B_VACC;
                end
                B_VACC:
                begin
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= (k_reg == 3'd7) ? B_VNUM : B_VMUL;
                end
                B_VNUM:
                begin
                    state_reg <= div_start ? B_VDIV : B_DEC;
                end
                B_VDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= B_DEC;
                    end
                end
                B_DEC:
                begin
                    state_reg <= B_DONE;
                end
                B_DONE:
                begin
                    if (load_out)
                    begin
                        out_valid_reg       <= 1'b1;
                        is_live_reg         <= live_reg;
                        micro_movement_reg  <= moving_reg;
                        jitter_variance_reg <= var_reg;
                        logit_stable_reg    <= stable_reg;
                        state_reg           <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    item_reg <= head;
                end
            end
            B_LOGIT:
            begin
                if (item_reg.absent)
                begin
                    var_reg    <= '0;
                    stable_reg <= 1'b0;
                    moving_reg <= 1'b0;
                    live_reg   <= 1'b0;
                end
                else
                begin
                    logit_store_reg[logit_widx_c] <= item_reg.logit;
                end
            end
            B_SETUP:
            begin
                stable_reg <= logit_full_c && (&pass_c);
                d2_reg     <= DEN_W'(unsigned'(d2_c));
                full_reg   <= aligned_full_c;
                slot_reg   <= slot_c;
            end
            B_PROD:
            begin
                if (d2_reg != '0)
                begin
                    if (k_reg[0])
                    begin
                        prod_a_reg <= py_c * item_reg.ex;
                        prod_b_reg <= px_c * item_reg.ey;
                    end
                    else
                    begin
                        prod_a_reg <= px_c * item_reg.ex;
                        prod_b_reg <= py_c * item_reg.ey;
                    end
                end
                else
                begin
                    prod_a_reg <= (k_reg[0] ? py_c : px_c) * WIDTH_SCALE;
                    prod_b_reg <= '0;
                end
            end
            B_NUM:
            begin
                neg_reg <= num_c[NUM_W-1];
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    co_reg[k_reg] <= co_c;
                end
            end
            B_SQ:
            begin
                sqo_reg <= unsigned'(sqo_c);
                sqn_reg <= unsigned'(sqn_c);
            end
            B_VMUL:
            begin
                vsq_reg <= vmag_c * vmag_c;
            end
            B_VACC:
            begin
                ssq_reg <= ((k_reg == 3'd0) ? SSQ_W'(0) : ssq_reg) + SSQ_W'(vsq_reg);
            end
            B_VNUM:
            begin
                if (aligned_count_reg == '0)
                begin
                    var_reg <= '0;
                end
                else if (!warm_c)
                begin
                    var_reg <= WARMUP_VARIANCE;
                end
            end
            B_VDIV:
            begin
                if (div_done)
                begin
                    var_reg <= div_sat ? '1 : div_q;
                end
            end
            B_DEC:
            begin
                moving_reg <= moving_c;
                live_reg   <= stable_reg ||
                              (moving_c && (item_reg.logit >= cfg.override_floor));
            end
            default:
            begin
            end
        endcase
    end

    // Landmark window memory: one read and one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_RD)
        begin
            rd_data_reg <= aligned_mem[addr_c];
        end
        if (state_reg == B_ACC)
        begin
            aligned_mem[addr_c] <= co_reg[k_reg];
        end
    end

endmodule

// ----- hw/rtl/liveness_jitter_decision.sv -----
// Top level of the liveness jitter decision block: configuration registers,
// front end queue and back end sequencer. Depends on lvjd_pkg, lvjd_front, lvjd_back.

// One frame enters per input transfer and leaves exactly one result transfer.
// A frame with no face clears both windows and its result (all zeros) goes
// straight to the output register. A frame with a face but zero width skips
// alignment. Throughput is set by the shared divider, which produces one
// quotient bit per cycle and runs eight times for the aligned coordinates
// (24 bits each) and, once the window is warm, once for the variance (32
// bits). A two-entry queue in the front end keeps accepting frames while the
// back end works, until it is full, and the output register holds a finished
// result until it is taken, so the next frame is processed meanwhile. The
// landmark window lives in a 120-entry memory tracked by a fill count and an
// oldest pointer, so no clearing pass is needed after reset. The configuration
// port is always ready; write it only while no frame is in flight. Writes to
// an index beyond the four registers are ignored.

module liveness_jitter_decision (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              face_present,
    input  logic signed [15:0]                logit_diff,
    input  logic [11:0]                       face_width,
    input  logic signed [15:0]                right_eye_dx,
    input  logic signed [15:0]                right_eye_dy,
    input  logic signed [15:0]                left_eye_dx,
    input  logic signed [15:0]                left_eye_dy,
    input  logic signed [15:0]                right_mouth_dx,
    input  logic signed [15:0]                right_mouth_dy,
    input  logic signed [15:0]                left_mouth_dx,
    input  logic signed [15:0]                left_mouth_dy,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              is_live,
    output logic                              micro_movement,
    output logic [31:0]                       jitter_variance,
    output logic                              logit_stable,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lvjd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lvjd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lvjd_pkg::*;

    lvjd_cfg_t   cfg_reg;
    lvjd_item_t  head;
    logic        head_valid;
    logic        pop;

    // Configuration writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.live_threshold <= LIVE_THRESHOLD_RESET;
            cfg_reg.variance_low   <= VARIANCE_LOW_RESET;
            cfg_reg.variance_high  <= VARIANCE_HIGH_RESET;
            cfg_reg.override_floor <= OVERRIDE_FLOOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LIVE_THRESHOLD: cfg_reg.live_threshold <= $signed(cfg_data[15:0]);
                CFG_VARIANCE_LOW:   cfg_reg.variance_low   <= cfg_data;
                CFG_VARIANCE_HIGH:  cfg_reg.variance_high  <= cfg_data;
                CFG_OVERRIDE_FLOOR: cfg_reg.override_floor <= $signed(cfg_data[15:0]);
                default:
                begin
                end
            endcase
        end
    end

    // Front end: accepts and classifies frames into the queue.
    lvjd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .face_present   (face_present),
        .logit_diff     (logit_diff),
        .face_width     (face_width),
        .right_eye_dx   (right_eye_dx),
        .right_eye_dy   (right_eye_dy),
        .left_eye_dx    (left_eye_dx),
        .left_eye_dy    (left_eye_dy),
        .right_mouth_dx (right_mouth_dx),
        .right_mouth_dy (right_mouth_dy),
        .left_mouth_dx  (left_mouth_dx),
        .left_mouth_dy  (left_mouth_dy),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop)
    );

    // Back end: windows, alignment, variance and the decision itself.
    lvjd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .head_valid      (head_valid),
        .pop             (pop),
        .cfg             (cfg_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .is_live         (is_live),
        .micro_movement  (micro_movement),
        .jitter_variance (jitter_variance),
        .logit_stable    (logit_stable)
    );

endmodule

// ----- hw/rtl/lvjd_checker.sv -----
// Port-level checks for the liveness jitter decision block, bound to the top.
// Depends only on the top level's clock, reset and result ports.

module lvjd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        is_live,
    input logic        micro_movement,
    input logic [31:0] jitter_variance,
    input logic        logit_stable
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its variance.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(jitter_variance))
        else $error("variance changed while stalled");

    // A stable logit window always makes the frame live.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && logit_stable |-> is_live)
        else $error("stable logits without live decision");

    // Without stable logits, only the movement override can make it live.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_live && !logit_stable |-> micro_movement)
        else $error("live decision without stable logits or movement");

endmodule

bind liveness_jitter_decision lvjd_checker u_lvjd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .is_live         (is_live),
    .micro_movement  (micro_movement),
    .jitter_variance (jitter_variance),
    .logit_stable    (logit_stable)
);
